// ===== sv/pidl_pkg.sv =====
`default_nettype none

package pidl_pkg;

    // Default list capacity
    localparam int DEPTH_DEF = 64;

    // Operation codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_DELETE = 2'd1;
    localparam logic [1:0] OP_READ   = 2'd2;

    // Place codes
    localparam logic [1:0] PL_INDEX = 2'd0;
    localparam logic [1:0] PL_FRONT = 2'd1;
    localparam logic [1:0] PL_END   = 2'd2;

    // Status codes
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;
    localparam logic [1:0] STAT_RANGE = 2'd3;

    typedef struct packed {
        logic [1:0]         operation;
        logic [1:0]         place;
        logic [6:0]         position;
        logic signed [31:0] value;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [31:0] read_value;
        logic [6:0]         entry_count;
    } t_out_item;

    // Broadcast shift command for the cell row
    typedef struct packed {
        logic shift_up;
        logic shift_down;
    } t_cell_ctrl;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

    // Registered levels of the 4-way read-out OR tree
    function automatic int tree_levels(input int depth);
        return ($clog2(depth) + 1) >> 1;
    endfunction

    // Node count at a given level of the OR tree (level 0 holds the leaves)
    function automatic int tree_nodes(input int depth, input int level);
        return ((depth - 1) >> (2 * level)) + 1;
    endfunction

endpackage

`default_nettype wire

// ===== sv/positional_insert_delete_list.sv =====
`default_nettype none

// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells,
// one entry per cell. Each input transaction is an insert, a delete or a read
// at the front, at the end or at a given index, and yields exactly one result
// transaction with status, read value and the new entry count. Inserts and
// deletes shift the cells at and above the target index by one place in
// parallel. A read routes the addressed cell through a registered 4-way OR
// tree of ceil(log4(DEPTH)) levels; errors leave the list unchanged. The
// next transaction can enter in the cycle the previous result is taken; a
// stalled result holds off the input.
module positional_insert_delete_list #(
    parameter int DEPTH = pidl_pkg::DEPTH_DEF
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_stall,
    input  wire pidl_pkg::t_in_item  i_in,
    output logic                     o_out_valid,
    input  wire                      i_out_stall,
    output pidl_pkg::t_out_item      o_out
);
    import pidl_pkg::*;

    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CW     = (CNT_W > 7) ? CNT_W : 7;
    localparam int LAT    = tree_levels(DEPTH);
    localparam int WAIT_W = $clog2(LAT + 1);

    // Control registers
    t_state              r_state;
    t_state              n_state;
    logic                r_out_valid;
    logic                n_out_valid;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    n_count;
    logic [WAIT_W-1:0]   r_wait;
    logic [WAIT_W-1:0]   n_wait;

    // Payload registers
    t_out_item           r_out;
    t_out_item           n_out;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [IDX_W-1:0]    n_rd_idx;

    logic                w_in_fire;
    logic [CW-1:0]       w_count_x;
    logic [CW-1:0]       w_idx_x;
    logic [IDX_W-1:0]    w_idx;
    logic [1:0]          w_status;
    logic [CNT_W-1:0]    w_cnt_new;
    logic [CW-1:0]       w_cnt_new_x;
    logic                w_is_read;
    logic                w_place_ok;
    t_cell_ctrl          w_ctrl;
    logic signed [31:0]  w_tree_out;

    logic signed [31:0]  w_data [DEPTH];
    logic signed [31:0]  w_leaf [DEPTH];

    assign o_in_stall  = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign w_count_x  = CW'(r_count);
    assign w_is_read  = (i_in.operation == OP_READ);
    assign w_place_ok = i_in.place inside {PL_INDEX, PL_FRONT, PL_END};

    // Resolve the target index from place and position
    always_comb begin
        case (i_in.place)
            PL_INDEX: w_idx_x = CW'(i_in.position);
            PL_FRONT: w_idx_x = '0;
            PL_END: begin
                if (i_in.operation == OP_INSERT) begin
                    w_idx_x = w_count_x;
                end else begin
                    w_idx_x = w_count_x - CW'(1);
                end
            end
            default:  w_idx_x = '0;
        endcase
    end

    assign w_idx = w_idx_x[IDX_W-1:0];

    // Check the request in priority order and work out the new count
    always_comb begin
        w_status  = STAT_OK;
        w_cnt_new = r_count;
        case (i_in.operation)
            OP_INSERT: begin
                if (!w_place_ok) begin
                    w_status = STAT_RANGE;
                end else if (r_count >= CNT_W'(DEPTH)) begin
                    w_status = STAT_FULL;
                end else if (w_idx_x > w_count_x) begin
                    w_status = STAT_RANGE;
                end else begin
                    w_cnt_new = r_count + CNT_W'(1);
                end
            end
            OP_DELETE, OP_READ: begin
                if (!w_place_ok) begin
                    w_status = STAT_RANGE;
                end else if (r_count == '0) begin
                    w_status = STAT_EMPTY;
                end else if (w_idx_x >= w_count_x) begin
                    w_status = STAT_RANGE;
                end else if (i_in.operation == OP_DELETE) begin
                    w_cnt_new = r_count - CNT_W'(1);
                end
            end
            default: w_status = STAT_RANGE;
        endcase
    end

    assign w_cnt_new_x = CW'(w_cnt_new);

    // Sequence transactions, drive the cell row and load the result
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        n_count     = r_count;
        n_wait      = r_wait;
        n_rd_idx    = r_rd_idx;
        w_ctrl      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    if (w_is_read && (w_status == STAT_OK)) begin
                        n_state  = S_READ;
                        n_rd_idx = w_idx;
                        n_wait   = WAIT_W'(LAT);
                    end else begin
                        n_out_valid       = 1'b1;
                        n_out.status      = w_status;
                        n_out.read_value  = '0;
                        n_out.entry_count = w_cnt_new_x[6:0];
                        n_count           = w_cnt_new;
                        if (w_status == STAT_OK) begin
                            w_ctrl.shift_up   = (i_in.operation == OP_INSERT);
                            w_ctrl.shift_down = (i_in.operation == OP_DELETE);
                        end
                    end
                end
            end
            S_READ: begin
                if (r_wait == '0) begin
                    n_state           = S_IDLE;
                    n_out_valid       = 1'b1;
                    n_out.status      = STAT_OK;
                    n_out.read_value  = w_tree_out;
                    n_out.entry_count = w_count_x[6:0];
                end else begin
                    n_wait = r_wait - WAIT_W'(1);
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Control state registers, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_count     <= '0;
            r_wait      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_count     <= n_count;
            r_wait      <= n_wait;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out    <= n_out;
        r_rd_idx <= n_rd_idx;
    end

    // Row of entry cells, each wired to its two neighbors
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [31:0] w_left;
        logic signed [31:0] w_right;
        if (i == 0) begin : g_first
            assign w_left = '0;
        end else begin : g_mid_l
            assign w_left = w_data[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign w_right = w_data[i];
        end else begin : g_mid_r
            assign w_right = w_data[i+1];
        end
        pidl_cell #(
            .DEPTH (DEPTH),
            .IDX   (i)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctrl   (w_ctrl),
            .i_idx    (w_idx),
            .i_rd_idx (r_rd_idx),
            .i_value  (i_in.value),
            .i_left   (w_left),
            .i_right  (w_right),
            .o_data   (w_data[i]),
            .o_leaf   (w_leaf[i])
        );
    end

    pidl_rdtree #(
        .DEPTH (DEPTH)
    ) u_rdtree (
        .i_clk  (i_clk),
        .i_leaf (w_leaf),
        .o_data (w_tree_out)
    );

endmodule

`default_nettype wire

// ===== sv/pidl_cell.sv =====
`default_nettype none

module pidl_cell #(
    parameter int DEPTH = 64,
    parameter int IDX   = 0
) (
    input  wire                             i_clk,
    input  wire pidl_pkg::t_cell_ctrl       i_ctrl,
    input  wire [$clog2(DEPTH)-1:0]         i_idx,
    input  wire [$clog2(DEPTH)-1:0]         i_rd_idx,
    input  wire logic signed [31:0]         i_value,
    input  wire logic signed [31:0]         i_left,
    input  wire logic signed [31:0]         i_right,
    output logic signed [31:0]              o_data,
    output logic signed [31:0]              o_leaf
);
    import pidl_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic signed [31:0] r_data;
    logic signed [31:0] n_data;

    // Take from the lower neighbor, the new value or the upper neighbor
    always_comb begin
        n_data = r_data;
        if (i_ctrl.shift_up) begin
            if (MY_IDX > i_idx) begin
                n_data = i_left;
            end else if (MY_IDX == i_idx) begin
                n_data = i_value;
            end
        end else if (i_ctrl.shift_down) begin
            if (MY_IDX >= i_idx) begin
                n_data = i_right;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

    // Present the entry to the read-out tree only when addressed
    assign o_leaf = (MY_IDX == i_rd_idx) ? r_data : '0;

endmodule

`default_nettype wire

// ===== sv/pidl_rdtree.sv =====
`default_nettype none

module pidl_rdtree #(
    parameter int DEPTH = 64
) (
    input  wire                     i_clk,
    input  wire logic signed [31:0] i_leaf [DEPTH],
    output logic signed [31:0]      o_data
);
    import pidl_pkg::*;

    localparam int LAT = tree_levels(DEPTH);

    logic signed [31:0] w_node [0:LAT][0:DEPTH-1];

    // Level 0 is the row of masked cell outputs
    for (genvar j = 0; j < DEPTH; j++) begin : g_leaf
        assign w_node[0][j] = i_leaf[j];
    end

    // Each level ORs groups of four nodes into one register
    for (genvar l = 1; l <= LAT; l++) begin : g_lvl
        localparam int NODES      = tree_nodes(DEPTH, l);
        localparam int NODES_PREV = tree_nodes(DEPTH, l - 1);
        for (genvar j = 0; j < DEPTH; j++) begin : g_node
            if (j < NODES) begin : g_used
                logic signed [31:0] w_kid [4];
                logic signed [31:0] r_node;
                logic signed [31:0] n_node;
                for (genvar k = 0; k < 4; k++) begin : g_kid
                    if (4 * j + k < NODES_PREV) begin : g_on
                        assign w_kid[k] = w_node[l-1][4*j+k];
                    end else begin : g_off
                        assign w_kid[k] = '0;
                    end
                end
                assign n_node = w_kid[0] | w_kid[1] | w_kid[2] | w_kid[3];
                always_ff @(posedge i_clk) begin
                    r_node <= n_node;
                end
                assign w_node[l][j] = r_node;
            end else begin : g_unused
                assign w_node[l][j] = '0;
            end
        end
    end

    assign o_data = w_node[LAT][0];

endmodule

`default_nettype wire

// ===== tb/tb_positional_insert_delete_list.sv =====
module tb_positional_insert_delete_list;
    timeunit 1ns;
    timeprecision 1ps;

    import pidl_pkg::*;

    localparam int LIST_DEPTH  = DEPTH_DEF;
    localparam int QUIET_LIMIT = 5000;
    localparam int TAIL_CYCLES = 20;
    localparam int PRINT_CAP   = 40;

    // Codes the block must reject; the package leaves them unnamed
    localparam logic [1:0] OP_UNUSED = 2'd3;
    localparam logic [1:0] PL_UNUSED = 2'd3;

    // Shadow of the list contents and fill level
    typedef struct packed {
        logic [LIST_DEPTH-1:0][31:0] cells;
        int                          n;
    } t_list;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_item = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_item;

    logic      in_fire = 1'b0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;
    int        fill_goal = LIST_DEPTH;
    int        quiet_cycles = 0;
    int        mismatches = 0;
    int        ops_taken = 0;
    int        peak_fill = 0;
    int        status_seen [4] = '{0, 0, 0, 0};

    t_list     model_list = '0;
    t_list     gen_list = '0;
    t_in_item  pending_ops [$];
    t_out_item expected_results [$];

    logic [31:0] extreme_values [4] = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF};

    positional_insert_delete_list dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_item),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_item)
    );

    initial forever #1 clk = ~clk;

    // Apply one list operation to a shadow list and return its result
    function automatic t_out_item apply_list_op(inout t_list st, input t_in_item it);
        t_out_item res;
        int        at;
        int        k;
        logic      place_ok;
        res.status     = STAT_OK;
        res.read_value = '0;
        place_ok       = 1'b1;
        at             = 0;
        case (it.place)
            PL_INDEX: at = int'(it.position);
            PL_FRONT: at = 0;
            PL_END:   at = (it.operation == OP_INSERT) ? st.n : st.n - 1;
            default:  place_ok = 1'b0;
        endcase
        if (it.operation == OP_INSERT) begin
            if (!place_ok) begin
                res.status = STAT_RANGE;
            end else if (st.n >= LIST_DEPTH) begin
                res.status = STAT_FULL;
            end else if (at > st.n) begin
                res.status = STAT_RANGE;
            end else begin
                // open a gap at the target and drop the value in
                for (k = st.n; k > at; k--) st.cells[k] = st.cells[k - 1];
                st.cells[at] = it.value;
                st.n++;
            end
        end else if (it.operation == OP_DELETE || it.operation == OP_READ) begin
            if (!place_ok) begin
                res.status = STAT_RANGE;
            end else if (st.n == 0) begin
                res.status = STAT_EMPTY;
            end else if (at >= st.n) begin
                res.status = STAT_RANGE;
            end else if (it.operation == OP_READ) begin
                res.read_value = st.cells[at];
            end else begin
                // close the gap left by the removed entry
                for (k = at; k + 1 < st.n; k++) st.cells[k] = st.cells[k + 1];
                st.n--;
            end
        end else begin
            res.status = STAT_RANGE;
        end
        res.entry_count = 7'(st.n);
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatches++;
        // keep the log bounded on a badly broken block
        if (mismatches <= PRINT_CAP)
            $display("MISMATCH at %0t: %s, got %0h, expected %0h", $time, what, got, want);
    endtask

    // Queue one operation and track the list state it will leave behind
    task automatic push_list_op(logic [1:0] op, logic [1:0] pl, logic [6:0] pos,
                                logic [31:0] val);
        t_in_item it;
        it.operation = op;
        it.place     = pl;
        it.position  = pos;
        it.value     = val;
        void'(apply_list_op(gen_list, it));
        pending_ops.push_back(it);
    endtask

    // Random operation steered toward a drifting fill level
    task automatic make_random_op();
        logic [1:0]  op;
        logic [1:0]  pl;
        logic [6:0]  pos;
        logic [31:0] val;
        int          n;
        int          ins_pct;
        int          roll;
        n = gen_list.n;
        if (n == fill_goal && $urandom_range(0, 19) == 0) begin
            roll = $urandom_range(0, 2);
            if (roll == 0) fill_goal = LIST_DEPTH;
            else if (roll == 1) fill_goal = 0;
            else fill_goal = $urandom_range(1, LIST_DEPTH - 1);
        end
        ins_pct = (n < fill_goal) ? 85 : (n > fill_goal) ? 15 : 50;
        roll = $urandom_range(0, 99);
        if (roll < 3) op = OP_UNUSED;
        else if (roll < 23) op = OP_READ;
        else op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_DELETE;
        roll = $urandom_range(0, 99);
        if (roll < 4) pl = PL_UNUSED;
        else if (roll < 60) pl = PL_INDEX;
        else if (roll < 80) pl = PL_FRONT;
        else pl = PL_END;
        // mostly in-range indexes, some anywhere in the field
        if ($urandom_range(0, 9) == 0) pos = 7'($urandom_range(0, 127));
        else if (op == OP_INSERT) pos = 7'($urandom_range(0, n));
        else pos = 7'($urandom_range(0, (n > 0) ? n - 1 : 0));
        if ($urandom_range(0, 9) == 0) val = extreme_values[$urandom_range(0, 3)];
        else val = $urandom;
        push_list_op(op, pl, pos, val);
    endtask

    // Hold until every queued operation has been sent and answered
    task automatic wait_list_idle();
        while (pending_ops.size() != 0 || in_valid || expected_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_list_phase(int n_ops, int idle_pct, int hold_pct);
        wait_list_idle();
        @(posedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = hold_pct;
        repeat (n_ops) make_random_op();
    endtask

    // Driver: hold a stalled transaction, otherwise send or idle
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid  <= 1'b0;
            out_stall <= 1'b0;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            if (in_valid && !in_fire) begin
                // hold
            end else if (pending_ops.size() != 0 &&
                         $urandom_range(0, 99) >= send_idle_pct) begin
                in_item  <= pending_ops.pop_front();
                in_valid <= 1'b1;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // Monitor: check results in order, then predict newly accepted operations
    always @(posedge clk) begin
        t_out_item want;
        if (!rst_n) begin
            in_fire <= 1'b0;
        end else begin
            in_fire <= in_valid && !in_stall;
            if (out_valid && !out_stall) begin
                status_seen[out_item.status]++;
                if (expected_results.size() == 0) begin
                    report_mismatch("result with nothing outstanding",
                                    32'(out_item.status), 32'(STAT_OK));
                end else begin
                    want = expected_results.pop_front();
                    if (out_item.status !== want.status)
                        report_mismatch("status", 32'(out_item.status), 32'(want.status));
                    if (out_item.read_value !== want.read_value)
                        report_mismatch("read_value", out_item.read_value, want.read_value);
                    if (out_item.entry_count !== want.entry_count)
                        report_mismatch("entry_count", 32'(out_item.entry_count),
                                        32'(want.entry_count));
                end
            end
            if (in_valid && !in_stall) begin
                expected_results.push_back(apply_list_op(model_list, in_item));
                ops_taken++;
                if (model_list.n > peak_fill) peak_fill = model_list.n;
            end
        end
    end

    // Watchdog: end the run when traffic stops
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
                         QUIET_LIMIT, expected_results.size());
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial begin
        int k;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list errors, then build a short list with corner values
        push_list_op(OP_READ,   PL_FRONT, 7'd0, $urandom);
        push_list_op(OP_DELETE, PL_END,   7'd0, $urandom);
        push_list_op(OP_INSERT, PL_INDEX, 7'd1, 32'h0000_0007);
        push_list_op(OP_INSERT, PL_INDEX, 7'd0, 32'h7FFF_FFFF);
        push_list_op(OP_INSERT, PL_FRONT, 7'd0, 32'h8000_0000);
        push_list_op(OP_INSERT, PL_END,   7'd0, 32'h0000_0000);
        push_list_op(OP_INSERT, PL_END,   7'd0, 32'hFFFF_FFFF);
        push_list_op(OP_INSERT, PL_INDEX, 7'd2, 32'h5555_5555);
        push_list_op(OP_INSERT, PL_INDEX, 7'd5, 32'hAAAA_AAAA);
        // read every entry, and one past the end
        for (k = 0; k <= 6; k++) push_list_op(OP_READ, PL_INDEX, 7'(k), $urandom);
        push_list_op(OP_READ,   PL_INDEX,  7'd127, $urandom);
        push_list_op(OP_UNUSED, PL_FRONT,  7'd0,   $urandom);
        push_list_op(OP_INSERT, PL_UNUSED, 7'd0,   $urandom);
        push_list_op(OP_DELETE, PL_UNUSED, 7'd0,   $urandom);
        push_list_op(OP_DELETE, PL_INDEX,  7'd2,   $urandom);
        push_list_op(OP_DELETE, PL_FRONT,  7'd0,   $urandom);
        push_list_op(OP_DELETE, PL_END,    7'd0,   $urandom);
        push_list_op(OP_DELETE, PL_INDEX,  7'd127, $urandom);
        push_list_op(OP_INSERT, PL_INDEX,  7'd127, $urandom);

        // random phases, each starting from a drained block
        run_list_phase(500, 0, 0);
        run_list_phase(450, 71, 0);
        run_list_phase(450, 0, 71);
        run_list_phase(450, 28, 28);

        wait_list_idle();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Covered %0d list operations over four handshake phases, peak fill %0d of %0d",
                 ops_taken, peak_fill, LIST_DEPTH);
        $display("Statuses seen: ok %0d, full %0d, empty %0d, out of range %0d; mismatches %0d",
                 status_seen[STAT_OK], status_seen[STAT_FULL], status_seen[STAT_EMPTY],
                 status_seen[STAT_RANGE], mismatches);
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

// ===== positional_insert_delete_list.f =====
sv/pidl_pkg.sv
sv/pidl_cell.sv
sv/pidl_rdtree.sv
sv/positional_insert_delete_list.sv
tb/tb_positional_insert_delete_list.sv
